// ===== src/wsfd_pkg.sv =====
package wsfd_pkg;

  typedef enum logic [6:0] {
    PH_H0   = 7'b0000001,
    PH_H1   = 7'b0000010,
    PH_EXT  = 7'b0000100,
    PH_KEY  = 7'b0001000,
    PH_DATA = 7'b0010000,
    PH_DONE = 7'b0100000,
    PH_ERR  = 7'b1000000
  } phase_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  localparam logic [2:0] KIND_ERROR    = 3'd0;
  localparam logic [2:0] KIND_TEXT     = 3'd1;
  localparam logic [2:0] KIND_BINARY   = 3'd2;
  localparam logic [2:0] KIND_CLOSE    = 3'd3;
  localparam logic [2:0] KIND_PING     = 3'd4;
  localparam logic [2:0] KIND_PONG     = 3'd5;
  localparam logic [2:0] KIND_CONT     = 3'd6;
  localparam logic [2:0] KIND_UNFINISH = 3'd7;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        chunk_done;
    logic [1:0]  status;
    logic        fin_flag;
    logic [3:0]  opcode_field;
    logic        mask_flag;
    logic [2:0]  frame_kind;
    logic [31:0] key_word;
    logic [63:0] payload_length;
  } wsfd_result_t;

  function automatic logic [2:0] classify(input logic fin, input logic [3:0] op);
    logic [2:0] kind;
    if (!fin) begin
      kind = KIND_UNFINISH;
    end else begin
      case (op)
        OP_TEXT:   kind = KIND_TEXT;
        OP_BINARY: kind = KIND_BINARY;
        OP_CLOSE:  kind = KIND_CLOSE;
        OP_PING:   kind = KIND_PING;
        OP_PONG:   kind = KIND_PONG;
        OP_CONT:   kind = KIND_CONT;
        default:   kind = KIND_ERROR;
      endcase
    end
    return kind;
  endfunction

endpackage

// ===== src/websocket_frame_deframer_core.sv =====
// WebSocket frame deframer. Feed one chunk as a byte stream, one byte per item, with s_tlast
// on the chunk's final byte. Each payload byte comes out unmasked with m_tuser high; the final
// byte of the chunk always yields an item with m_tlast high carrying the final status and the
// parsed header fields; header and trailing bytes that are not final yield nothing. The block
// takes one byte every clock unless stalled by m_tready, registering its result; the single
// output register is the only buffering, so s_tready follows m_tready while a result waits.
module websocket_frame_deframer_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tlast,   // end_of_chunk
  output logic         m_tvalid,
  input  logic         m_tready,
  // payload_byte[7:0], status[9:8], fin_flag[10], opcode_field[14:11], mask_flag[15],
  // frame_kind[18:16], key_word[50:19], payload_length[114:51], zero pad[119:115]
  output logic [119:0] m_tdata,
  output logic         m_tuser,   // byte_valid
  output logic         m_tlast    // chunk_done
);
  import wsfd_pkg::*;

  logic         accept;
  logic         emit;
  wsfd_result_t result;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  wsfd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .data_byte    (s_tdata),
    .end_of_chunk (s_tlast),
    .emit         (emit),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_tdata <= {5'd0, result.payload_length, result.key_word, result.frame_kind,
                  result.mask_flag, result.opcode_field, result.fin_flag, result.status,
                  result.payload_byte};
      m_tuser <= result.byte_valid;
      m_tlast <= result.chunk_done;
    end
  end

endmodule

// ===== src/wsfd_parser.sv =====
module wsfd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_chunk,
  output logic                 emit,
  output wsfd_pkg::wsfd_result_t result
);
  import wsfd_pkg::*;

  phase_t      phase, phase_next;
  logic [63:0] length_accum, length_accum_next;
  logic [6:0]  length_code, length_code_next;
  logic [5:0]  header_flags, header_flags_next;
  logic [31:0] key_store, key_store_next;
  logic [63:0] payload_count, payload_count_next;
  logic [2:0]  kind_reg, kind_reg_next;

  logic [63:0] count_inc;
  logic [31:0] key_shifted;
  logic [7:0]  pbyte;
  logic        valid;
  logic [1:0]  status;

  assign count_inc   = payload_count + 64'd1;
  assign key_shifted = key_store >> {payload_count[1:0], 3'b000};

  always_comb begin
    phase_next         = phase;
    length_accum_next  = length_accum;
    length_code_next   = length_code;
    header_flags_next  = header_flags;
    key_store_next     = key_store;
    payload_count_next = payload_count;
    kind_reg_next      = kind_reg;
    pbyte              = 8'd0;
    valid              = 1'b0;
    unique case (phase)
      PH_H0: begin
        header_flags_next = {data_byte[7], 1'b0, data_byte[3:0]};
        kind_reg_next     = classify(data_byte[7], data_byte[3:0]);
        phase_next        = PH_H1;
      end
      PH_H1: begin
        header_flags_next[4] = header_flags[4] | data_byte[7];
        length_code_next     = data_byte[6:0];
        if (kind_reg == KIND_ERROR) begin
          phase_next = PH_ERR;
        end else if (data_byte[6:0] >= LEN_CODE_16) begin
          length_accum_next  = 64'd0;
          payload_count_next = 64'd0;
          phase_next         = PH_EXT;
        end else begin
          length_accum_next  = {57'd0, data_byte[6:0]};
          payload_count_next = 64'd0;
          if (header_flags_next[4]) begin
            phase_next = PH_KEY;
          end else if (data_byte[6:0] == 7'd0) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_EXT: begin
        length_accum_next  = {length_accum[55:0], data_byte};
        payload_count_next = count_inc;
        if (count_inc >= ((length_code == LEN_CODE_16) ? 64'd2 : 64'd8)) begin
          payload_count_next = 64'd0;
          if (header_flags[4]) begin
            phase_next = PH_KEY;
          end else if (length_accum_next == 64'd0) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_KEY: begin
        key_store_next     = key_store | ({24'd0, data_byte} << {payload_count[1:0], 3'b000});
        payload_count_next = count_inc;
        if (count_inc >= 64'd4) begin
          payload_count_next = 64'd0;
          phase_next         = (length_accum == 64'd0) ? PH_DONE : PH_DATA;
        end
      end
      PH_DATA: begin
        pbyte              = data_byte ^ key_shifted[7:0];
        valid              = 1'b1;
        payload_count_next = count_inc;
        if (count_inc == length_accum) phase_next = PH_DONE;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status = ST_OK;
    if (end_of_chunk) begin
      if (phase_next == PH_H1)        status = ST_SHORT;
      else if (phase_next == PH_ERR)  status = ST_BAD_TYPE;
      else if (phase_next == PH_DONE) status = ST_OK;
      else                            status = ST_TRUNCATED;
    end
  end

  assign emit = valid | end_of_chunk;

  always_comb begin
    result.payload_byte   = pbyte;
    result.byte_valid     = valid;
    result.chunk_done     = end_of_chunk;
    result.status         = status;
    result.fin_flag       = header_flags_next[5];
    result.opcode_field   = header_flags_next[3:0];
    result.mask_flag      = header_flags_next[4];
    result.frame_kind     = kind_reg_next;
    result.key_word       = key_store_next;
    result.payload_length = length_accum_next;
  end

  // return to the idle header state after every chunk's final byte
  always_ff @(posedge clk) begin
    if (rst || (step && end_of_chunk)) begin
      phase         <= PH_H0;
      length_accum  <= 64'd0;
      length_code   <= 7'd0;
      header_flags  <= 6'd0;
      key_store     <= 32'd0;
      payload_count <= 64'd0;
      kind_reg      <= KIND_ERROR;
    end else if (step) begin
      phase         <= phase_next;
      length_accum  <= length_accum_next;
      length_code   <= length_code_next;
      header_flags  <= header_flags_next;
      key_store     <= key_store_next;
      payload_count <= payload_count_next;
      kind_reg      <= kind_reg_next;
    end
  end

endmodule

// ===== src/wsfd_checker.sv =====
module wsfd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [119:0] m_tdata,
  input logic         m_tuser,
  input logic         m_tlast
);
  import wsfd_pkg::*;

  // hold a stalled item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output item changed");

  // an item without a payload byte exists only for the chunk's final byte
  a_nonpayload_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0)
    else $error("non-payload item not at end of chunk");

  a_status_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[9:8] == ST_OK)
    else $error("status set before end of chunk");

  // an invalid frame type never lets a payload byte through
  a_no_payload_on_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[18:16] != KIND_ERROR)
    else $error("payload emitted for invalid frame type");

  a_item_needs_input: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
    else $error("output item appeared without an accepted input item");

endmodule

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (.*);
